FILE: hw/rtl/isfp_pkg.sv
package isfp_pkg;

  // frame framing constants
  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam int         PayloadLen = 8;
  localparam int         WordCount  = PayloadLen / 2;
  localparam int         IdxW       = $clog2(PayloadLen);

  // byte positions within a frame
  localparam logic [3:0] CntIdle  = 4'd0;
  localparam logic [3:0] CntType  = 4'd1;
  localparam logic [3:0] CntFirst = 4'd2;
  localparam logic [3:0] CntLast  = 4'd10;

  // result kind codes
  localparam logic KindRate  = 1'b0;
  localparam logic KindAngle = 1'b1;

  typedef logic [15:0] word_t;

  typedef struct packed {
    logic                      kind;
    logic [WordCount-1:0][15:0] words;
  } frame_t;

  typedef struct packed {
    logic [3:0] count;
    logic       at_close;
  } asm_status_t;

endpackage

FILE: hw/rtl/isfp_assembler.sv
module isfp_assembler (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic [7:0]            rx_byte,
  output isfp_pkg::asm_status_t status,
  output logic                  res_valid,
  output isfp_pkg::frame_t      res
);
  import isfp_pkg::*;

  logic [3:0]      byte_count;
  logic [3:0]      byte_count_next;
  logic [7:0]      type_byte;
  logic [7:0]      payload_bytes [PayloadLen];
  logic [3:0]      slot_full;
  logic [IdxW-1:0] slot;
  logic            at_close;
  logic            type_ok;

  // close on the checksum byte, or on any out-of-range count
  assign at_close  = (byte_count >= CntLast);
  assign slot_full = byte_count - CntFirst;
  assign slot      = slot_full[IdxW-1:0];

  // byte counter
  always_comb begin
    byte_count_next = byte_count;
    if (in_fire) begin
      if (byte_count == CntIdle) begin
        if (rx_byte == HdrByte) begin
          byte_count_next = CntType;
        end
      end else if (at_close) begin
        byte_count_next = CntIdle;
      end else begin
        byte_count_next = byte_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= CntIdle;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  // type and payload store
  always_ff @(posedge clk) begin
    if (in_fire && byte_count == CntType) begin
      type_byte <= rx_byte;
    end
    if (in_fire && byte_count >= CntFirst && !at_close) begin
      payload_bytes[slot] <= rx_byte;
    end
  end

  // result decode at frame close
  assign type_ok   = (type_byte == TypeRate) || (type_byte == TypeAngle);
  assign res_valid = in_fire && at_close && type_ok;

  always_comb begin
    res.kind = (type_byte == TypeAngle) ? KindAngle : KindRate;
    for (int k = 0; k < WordCount; k++) begin
      res.words[k] = {payload_bytes[2*k+1], payload_bytes[2*k]};
    end
  end

  assign status.count    = byte_count;
  assign status.at_close = at_close;

endmodule

FILE: hw/rtl/isfp_out_reg.sv
module isfp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  isfp_pkg::frame_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output isfp_pkg::frame_t held
);
  import isfp_pkg::*;

  logic out_valid_next;

  // result slot occupancy
  always_comb begin
    out_valid_next = out_valid;
    if (res_valid) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

endmodule

FILE: hw/rtl/imu_serial_frame_parser.sv
// a result is registered and appears in the cycle after the transfer of the frame's checksum byte
// throughput: one byte per cycle; a waiting result stalls input only on a checksum byte
// the frame closer is a 4-bit byte counter with an eight-byte payload store
// reset (rst, synchronous): clears the byte count and the result valid flag;
// stored type and payload bytes keep their contents
module imu_serial_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               frame_kind,
  output logic signed [15:0] word_0,
  output logic signed [15:0] word_1,
  output logic signed [15:0] word_2,
  output logic signed [15:0] word_3
);
  import isfp_pkg::*;

  asm_status_t status;
  frame_t      res;
  frame_t      held;
  logic        res_valid;
  logic        in_fire;

  // only a closing byte needs the result slot free
  assign in_ready = !status.at_close || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  isfp_assembler u_asm (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .rx_byte   (rx_byte),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

  isfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .held      (held)
  );

  assign frame_kind = held.kind;
  assign word_0     = held.words[0];
  assign word_1     = held.words[1];
  assign word_2     = held.words[2];
  assign word_3     = held.words[3];

  // count stays within a frame
  assert property (@(posedge clk) disable iff (rst) status.count <= CntLast)
    else $error("byte count out of range");

  // a new result only follows a closing byte transfer
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && status.at_close))
    else $error("result without frame close");

  // a non-header byte at idle keeps the parser idle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && status.count == CntIdle && rx_byte != HdrByte)
      |=> status.count == CntIdle)
    else $error("lost header sync");

  // a closing byte is never taken while a result would be overwritten
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(held)))
    else $error("pending result overwritten");

endmodule
